// ----- sv/pwmm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwmm_pkg
// Codes, register indexes, reset values and the result word layout for the
// periodic wake and multi-press mode core.
// ----------------------------------------------------------------------------
package pwmm_pkg;

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_PRESS    = 3'd1,
		OP_DONE     = 3'd2,
		OP_SET_CHK  = 3'd3,
		OP_LOAD     = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		REG_MIN_PERIOD     = 2'd0,
		REG_GPS_LEAD       = 2'd1,
		REG_PRESS_WINDOW   = 2'd2,
		REG_PRESSES_NEEDED = 2'd3
	} reg_idx_t;

	localparam logic [31:0] MIN_PERIOD_RST     = 32'd60;
	localparam logic [15:0] GPS_LEAD_RST       = 16'd30;
	localparam logic [6:0]  PRESS_WINDOW_RST   = 7'd5;
	localparam logic [3:0]  PRESSES_NEEDED_RST = 4'd3;
	localparam logic [3:0]  PRESS_COUNT_MAX    = 4'hF;

	// result word, highest bit first (sensor_wake is bit 0)
	typedef struct packed {
		logic accepted;
		logic mode;
		logic mode_led;
		logic press_led;
		logic gps_wake;
		logic sensor_wake;
	} result_t;

endpackage
`default_nettype wire

// ----- sv/periodic_wake_and_multipress_mode_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_wake_and_multipress_mode_core
// Tick-driven period counter with sensor and one-shot GPS wake requests,
// plus a decaying multi-press window that toggles the transmission mode.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+-------------------------------
//  s_*       | in        | s_tvalid / s_tready  | tdata: new_period, command_id
//            |           |                      | tuser: op
//  m_*       | out       | m_tvalid / m_tready  | tdata: six result flags
//  cfg_*     | in        | cfg_we (no wait)     | cfg_index, cfg_wdata
//
//  One word in, one result word out, one word per cycle while m_tready holds.
//  The state update is a single pass of logic from the state registers into
//  the result register; the next word can follow on the very next cycle.
//  A result register plus a one-word skid stage part the two sides, so an
//  input word is still taken while one result waits; s_tready drops only
//  when both are full. Reset returns all state to its start values at once.
//
module periodic_wake_and_multipress_mode_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] new_period, [39:32] command_id
	input  wire logic [2:0]  s_tuser,   // [2:0] op
	// result stream
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // [0] sensor_wake, [1] gps_wake,
	                                    // [2] press_led, [3] mode_led,
	                                    // [4] mode, [5] accepted, [7:6] zero
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	// configuration registers
	logic [31:0] min_period_q;
	logic [15:0] gps_lead_q;
	logic [6:0]  press_window_q;
	logic [3:0]  presses_needed_q;

	// block state
	logic [31:0] tick_count_q;
	logic [31:0] period_q;
	logic        task_busy_q;
	logic        gps_req_q;
	logic        press_pend_q;
	logic [3:0]  press_count_q;
	logic [6:0]  window_q;
	logic        mode_q;
	logic        press_led_q;
	logic        mode_led_q;
	logic [7:0]  last_cmd_q;

	// output register and skid stage
	logic                  out_v_q;
	pwmm_pkg::result_t     out_q;
	logic                  skid_v_q;
	pwmm_pkg::result_t     skid_q;

	logic        in_acc;
	logic        out_pop;
	pwmm_pkg::op_t op;
	logic [31:0] new_period;
	logic [7:0]  cmd_id;

	// next state
	logic [31:0] tick_count_d;
	logic [31:0] period_d;
	logic        task_busy_d;
	logic        gps_req_d;
	logic        press_pend_d;
	logic [3:0]  press_count_d;
	logic [6:0]  window_d;
	logic        mode_d;
	logic        press_led_d;
	logic        mode_led_d;
	logic [7:0]  last_cmd_d;
	pwmm_pkg::result_t res;

	// tick intermediates
	logic [31:0] tc_inc;
	logic        period_met;
	logic [31:0] tc_tick;
	logic        busy_tick;
	logic        gps_hit;
	logic [3:0]  pc_tick;
	logic [6:0]  win_tick;
	logic        toggle;

	assign op         = pwmm_pkg::op_t'(s_tuser);
	assign new_period = s_tdata[31:0];
	assign cmd_id     = s_tdata[39:32];

	assign s_tready = !skid_v_q;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_v_q;
	assign out_pop  = out_v_q && m_tready;
	assign m_tdata  = {2'b00, out_q};

	// tick path: count, period check, GPS check on the updated count
	assign tc_inc     = tick_count_q + 32'd1;
	assign period_met = (tc_inc >= period_q);
	assign tc_tick    = period_met ? 32'd0 : tc_inc;
	assign busy_tick  = task_busy_q || period_met;
	assign gps_hit    = ((period_q - {16'd0, gps_lead_q}) == tc_tick)
	                    && !gps_req_q && !busy_tick;
	// pending press is counted, saturating
	assign pc_tick    = (press_pend_q && (press_count_q != pwmm_pkg::PRESS_COUNT_MAX))
	                    ? press_count_q + 4'd1 : press_count_q;
	// window decays, stopping at zero
	assign win_tick   = (window_q != 7'd0) ? window_q - 7'd1 : 7'd0;
	assign toggle     = (win_tick != 7'd0) && (pc_tick >= presses_needed_q);

	always_comb begin
		tick_count_d  = tick_count_q;
		period_d      = period_q;
		task_busy_d   = task_busy_q;
		gps_req_d     = gps_req_q;
		press_pend_d  = press_pend_q;
		press_count_d = press_count_q;
		window_d      = window_q;
		mode_d        = mode_q;
		press_led_d   = press_led_q;
		mode_led_d    = mode_led_q;
		last_cmd_d    = last_cmd_q;
		res           = '0;
		unique case (op)
			pwmm_pkg::OP_TICK: begin
				tick_count_d     = tc_tick;
				task_busy_d      = busy_tick || gps_hit;
				gps_req_d        = gps_req_q || gps_hit;
				res.sensor_wake  = period_met && !task_busy_q;
				res.gps_wake     = gps_hit;
				press_pend_d     = 1'b0;
				if (press_pend_q) begin
					press_led_d = 1'b0;
				end
				if (win_tick == 7'd0) begin
					window_d      = 7'd0;
					press_count_d = 4'd0;
					mode_led_d    = 1'b0;
				end else if (toggle) begin
					mode_d        = !mode_q;
					period_d      = 32'd0;
					mode_led_d    = 1'b1;
					window_d      = 7'd0;
					press_count_d = 4'd0;
				end else begin
					window_d      = win_tick;
					press_count_d = pc_tick;
				end
			end
			pwmm_pkg::OP_PRESS: begin
				window_d     = press_window_q;
				press_led_d  = 1'b1;
				press_pend_d = 1'b1;
			end
			pwmm_pkg::OP_DONE: begin
				task_busy_d = 1'b0;
			end
			pwmm_pkg::OP_SET_CHK: begin
				// only a new command with a long enough period is taken
				if ((cmd_id != last_cmd_q) && (new_period >= min_period_q)) begin
					tick_count_d = 32'd0;
					period_d     = new_period;
					last_cmd_d   = cmd_id;
					res.accepted = 1'b1;
				end
			end
			pwmm_pkg::OP_LOAD: begin
				tick_count_d = 32'd0;
				period_d     = new_period;
				res.accepted = 1'b1;
			end
			default: begin
			end
		endcase
		res.press_led = press_led_d;
		res.mode_led  = mode_led_d;
		res.mode      = mode_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_period_q     <= pwmm_pkg::MIN_PERIOD_RST;
			gps_lead_q       <= pwmm_pkg::GPS_LEAD_RST;
			press_window_q   <= pwmm_pkg::PRESS_WINDOW_RST;
			presses_needed_q <= pwmm_pkg::PRESSES_NEEDED_RST;
		end else if (cfg_we) begin
			unique case (pwmm_pkg::reg_idx_t'(cfg_index))
				pwmm_pkg::REG_MIN_PERIOD:     min_period_q     <= cfg_wdata;
				pwmm_pkg::REG_GPS_LEAD:       gps_lead_q       <= cfg_wdata[15:0];
				pwmm_pkg::REG_PRESS_WINDOW:   press_window_q   <= cfg_wdata[6:0];
				pwmm_pkg::REG_PRESSES_NEEDED: presses_needed_q <= cfg_wdata[3:0];
				default: begin
				end
			endcase
		end
	end

	// block state, updated once per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q  <= 32'd0;
			period_q      <= 32'd0;
			task_busy_q   <= 1'b0;
			gps_req_q     <= 1'b0;
			press_pend_q  <= 1'b0;
			press_count_q <= 4'd0;
			window_q      <= 7'd0;
			mode_q        <= 1'b1;
			press_led_q   <= 1'b0;
			mode_led_q    <= 1'b0;
			last_cmd_q    <= 8'd0;
		end else if (in_acc) begin
			tick_count_q  <= tick_count_d;
			period_q      <= period_d;
			task_busy_q   <= task_busy_d;
			gps_req_q     <= gps_req_d;
			press_pend_q  <= press_pend_d;
			press_count_q <= press_count_d;
			window_q      <= window_d;
			mode_q        <= mode_d;
			press_led_q   <= press_led_d;
			mode_led_q    <= mode_led_d;
			last_cmd_q    <= last_cmd_d;
		end
	end

	// output register and skid: skid only fills while the output is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_acc) begin
			if (out_v_q && !out_pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (out_pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_pop) begin
				out_q <= skid_q;
			end
		end else if (in_acc) begin
			if (out_v_q && !out_pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

`ifndef ASSERT_OFF
	// skid never holds a word unless the output register does too
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output register empty");

	// a sensor wake marks the task busy, so no GPS wake on the same tick
	a_one_wake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("sensor and GPS wake in one result");

	// a mode toggle always clears the period
	a_toggle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (mode_d != mode_q)) |=> (period_q == 32'd0))
		else $error("mode toggled without clearing the period");
`endif

endmodule
`default_nettype wire

// ----- sim/wake_mode_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wake_mode_checker
// Watches the input, result and register write ports of the wake and mode
// core, works out the flags each input word should give and checks every
// result word against them in order.
// ----------------------------------------------------------------------------
module wake_mode_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,   // [31:0] new_period, [39:32] command_id
	input  wire logic [2:0]  s_tuser,   // [2:0] op
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // [0] sensor_wake, [1] gps_wake,
	                                    // [2] press_led, [3] mode_led,
	                                    // [4] mode, [5] accepted, [7:6] zero
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output int               mismatches,
	output int               flags_owed
);

	logic [31:0] min_period;
	logic [15:0] gps_lead;
	logic [6:0]  press_window;
	logic [3:0]  presses_needed;

	logic [31:0] tick_cnt;
	logic [31:0] period;
	logic        busy;
	logic        gps_done;
	logic        press_pend;
	logic [3:0]  press_cnt;
	logic [6:0]  window;
	logic        mode;
	logic        press_led;
	logic        mode_led;
	logic [7:0]  last_cmd;

	pwmm_pkg::result_t flags_due[$];

	function automatic string field_label(int i);
		case (i)
		0: return "sensor_wake";
		1: return "gps_wake";
		2: return "press_led";
		3: return "mode_led";
		4: return "mode";
		default: return "accepted";
		endcase
	endfunction

	// one word through the block state, giving its result flags
	function automatic pwmm_pkg::result_t step_wake_logic(logic [2:0] op,
	                                                      logic [31:0] np,
	                                                      logic [7:0] cid);
		pwmm_pkg::result_t r;
		r = '0;
		case (op)
		pwmm_pkg::OP_TICK: begin
			tick_cnt = tick_cnt + 32'd1;
			if (tick_cnt >= period) begin
				if (!busy) begin
					busy = 1'b1;
					r.sensor_wake = 1'b1;
				end
				tick_cnt = '0;
			end
			if (period - {16'd0, gps_lead} == tick_cnt && !gps_done && !busy) begin
				gps_done = 1'b1;
				busy = 1'b1;
				r.gps_wake = 1'b1;
			end
			if (press_pend) begin
				press_led = 1'b0;
				press_pend = 1'b0;
				if (press_cnt != pwmm_pkg::PRESS_COUNT_MAX)
					press_cnt = press_cnt + 4'd1;
			end
			if (window != '0)
				window = window - 7'd1;
			if (window != '0) begin
				if (press_cnt >= presses_needed) begin
					mode = ~mode;
					period = '0;
					mode_led = 1'b1;
					window = '0;
					press_cnt = '0;
				end
			end else begin
				mode_led = 1'b0;
				press_cnt = '0;
			end
		end
		pwmm_pkg::OP_PRESS: begin
			window = press_window;
			press_led = 1'b1;
			press_pend = 1'b1;
		end
		pwmm_pkg::OP_DONE: busy = 1'b0;
		pwmm_pkg::OP_SET_CHK: begin
			if (cid != last_cmd && np >= min_period) begin
				tick_cnt = '0;
				period = np;
				last_cmd = cid;
				r.accepted = 1'b1;
			end
		end
		pwmm_pkg::OP_LOAD: begin
			tick_cnt = '0;
			period = np;
			r.accepted = 1'b1;
		end
		default: ;
		endcase
		r.press_led = press_led;
		r.mode_led = mode_led;
		r.mode = mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pwmm_pkg::result_t got;
		pwmm_pkg::result_t want;
		if (!arst_n) begin
			min_period = pwmm_pkg::MIN_PERIOD_RST;
			gps_lead = pwmm_pkg::GPS_LEAD_RST;
			press_window = pwmm_pkg::PRESS_WINDOW_RST;
			presses_needed = pwmm_pkg::PRESSES_NEEDED_RST;
			tick_cnt = '0;
			period = '0;
			busy = 1'b0;
			gps_done = 1'b0;
			press_pend = 1'b0;
			press_cnt = '0;
			window = '0;
			mode = 1'b1;
			press_led = 1'b0;
			mode_led = 1'b0;
			last_cmd = '0;
			flags_due.delete();
			flags_owed = 0;
			mismatches = 0;
		end else begin
			// results first: a word taken at this edge cannot be answered at it
			if (m_tvalid && m_tready) begin
				got = pwmm_pkg::result_t'(m_tdata[5:0]);
				if (flags_due.size() == 0) begin
					mismatches++;
					$display("%0t: result word %02h with none expected", $time, m_tdata);
				end else begin
					want = flags_due.pop_front();
					for (int i = 0; i < 6; i++)
						if (got[i] !== want[i]) begin
							mismatches++;
							$display("%0t: %s expected %0b got %0b", $time,
							         field_label(i), want[i], got[i]);
						end
					if (m_tdata[7:6] !== 2'b00) begin
						mismatches++;
						$display("%0t: pad bits expected 00 got %02b", $time, m_tdata[7:6]);
					end
				end
			end
			if (cfg_we)
				case (cfg_index)
				pwmm_pkg::REG_MIN_PERIOD:     min_period = cfg_wdata;
				pwmm_pkg::REG_GPS_LEAD:       gps_lead = cfg_wdata[15:0];
				pwmm_pkg::REG_PRESS_WINDOW:   press_window = cfg_wdata[6:0];
				pwmm_pkg::REG_PRESSES_NEEDED: presses_needed = cfg_wdata[3:0];
				default: ;
				endcase
			if (s_tvalid && s_tready)
				flags_due.push_back(step_wake_logic(s_tuser, s_tdata[31:0], s_tdata[39:32]));
			flags_owed = flags_due.size();
		end
	end

endmodule
`default_nettype wire

// ----- sim/tb_periodic_wake_and_multipress_mode_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_periodic_wake_and_multipress_mode_core
// Drives tick, press, task-done, set-period and load-period words into the
// core through bursty sends against a stalling receiver, sweeps the four
// registers through several settings and leaves all checking to the
// wake_mode_checker beside the core.
// ----------------------------------------------------------------------------
module tb_periodic_wake_and_multipress_mode_core;

	localparam int TIMEOUT_CYCLES  = 300000;
	localparam int SETTLE_CYCLES   = 16;   // result and skid stages, with margin
	localparam int PHASES          = 8;
	localparam int WORDS_PER_PHASE = 165;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;      // [31:0] new_period, [39:32] command_id
	logic [2:0]  s_tuser   = '0;      // [2:0] op
	logic        m_tvalid;
	logic        m_tready  = 1'b1;
	logic [7:0]  m_tdata;             // [0] sensor_wake .. [5] accepted
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	int          mismatches;
	int          flags_owed;
	int unsigned cycles    = 0;
	int          burst_left = 0;
	int          max_gap   = 3;       // longest sender gap in this phase, 0 = none
	int          stall_pct = 0;       // receiver stall odds, redrawn in stretches
	int          words_sent = 0;

	// register values last written, used only to shape the stimulus
	logic [31:0] cur_min    = pwmm_pkg::MIN_PERIOD_RST;
	logic [6:0]  cur_window = pwmm_pkg::PRESS_WINDOW_RST;
	logic [3:0]  cur_needed = pwmm_pkg::PRESSES_NEEDED_RST;

	periodic_wake_and_multipress_mode_core dut (.*);
	wake_mode_checker chk (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == TIMEOUT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: stall odds change in stretches, some of them never stalling
	always @(negedge clk) begin
		if (cycles % 128 == 0)
			case ($urandom_range(3))
			0: stall_pct = 0;
			1: stall_pct = 25;
			2: stall_pct = 50;
			default: stall_pct = 85;
			endcase
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// one word, after a random gap at the start of each burst; returns just
	// after the edge that took it, with tvalid still high
	task automatic send_word(input logic [2:0] op, input logic [31:0] np,
	                         input logic [7:0] cid);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (max_gap != 0)
				gap = $urandom_range(0, max_gap);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {cid, np};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	// stop sending and wait until every result word has come back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (flags_owed != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input pwmm_pkg::reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// all four registers; narrow ones get junk above their width
	task automatic configure(input logic [31:0] minp, input logic [15:0] lead,
	                         input logic [6:0] win, input logic [3:0] need);
		write_reg(pwmm_pkg::REG_MIN_PERIOD, minp);
		write_reg(pwmm_pkg::REG_GPS_LEAD, {16'($urandom), lead});
		write_reg(pwmm_pkg::REG_PRESS_WINDOW, {25'($urandom), win});
		write_reg(pwmm_pkg::REG_PRESSES_NEEDED, {28'($urandom), need});
		cur_min    = minp;
		cur_window = win;
		cur_needed = need;
	endtask

	// one random item, or a run of presses each followed by a tick or two
	task automatic random_item();
		int          pick;
		logic [31:0] np;
		logic [7:0]  cid;
		pick = $urandom_range(99);
		np   = $urandom;
		cid  = 8'($urandom);
		if (pick < 40)
			send_word(pwmm_pkg::OP_TICK, np, cid);
		else if (pick < 52)
			send_word(pwmm_pkg::OP_PRESS, np, cid);
		else if (pick < 64)
			send_word(pwmm_pkg::OP_DONE, np, cid);
		else if (pick < 76) begin
			// periods around the floor, and a small pool of ids so repeats happen
			case ($urandom_range(4))
			0: np = cur_min - 32'd1;
			1: np = cur_min;
			2: np = cur_min + $urandom_range(0, 40);
			3: np = $urandom_range(0, 100);
			default: ;
			endcase
			if ($urandom_range(3) != 0)
				cid = 8'($urandom_range(0, 3));
			send_word(pwmm_pkg::OP_SET_CHK, np, cid);
		end else if (pick < 86) begin
			if ($urandom_range(7) != 0)
				np = $urandom_range(0, 90);
			send_word(pwmm_pkg::OP_LOAD, np, cid);
		end else if (pick < 90)
			send_word(3'($urandom_range(5, 7)), np, cid);
		else
			repeat (cur_needed + 1) begin
				send_word(pwmm_pkg::OP_PRESS, $urandom, 8'($urandom));
				repeat ($urandom_range(1, 2))
					send_word(pwmm_pkg::OP_TICK, $urandom, 8'($urandom));
			end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, registers at their reset values
		send_word(pwmm_pkg::OP_TICK, '0, '0);              // period zero: sensor wake
		send_word(pwmm_pkg::OP_TICK, '0, '0);              // task busy: no wake
		send_word(pwmm_pkg::OP_DONE, '0, '0);
		send_word(pwmm_pkg::OP_SET_CHK, 32'd59, 8'd1);     // below the floor
		send_word(pwmm_pkg::OP_SET_CHK, 32'd60, 8'd0);     // same id as stored
		send_word(pwmm_pkg::OP_SET_CHK, 32'd60, 8'd1);     // taken
		send_word(pwmm_pkg::OP_SET_CHK, 32'd100, 8'd1);    // id repeated
		send_word(pwmm_pkg::OP_LOAD, 32'd32, 8'hFF);       // unchecked, GPS due at 2
		send_word(pwmm_pkg::OP_TICK, '0, '0);
		send_word(pwmm_pkg::OP_TICK, '0, '0);              // one-shot GPS wake
		send_word(pwmm_pkg::OP_DONE, '0, '0);
		send_word(3'd5, 32'hFFFF_FFFF, 8'hFF);             // unknown ops
		send_word(3'd6, 32'hFFFF_FFFF, 8'hFF);
		send_word(3'd7, '0, '0);
		send_word(pwmm_pkg::OP_SET_CHK, 32'hFFFF_FFFF, 8'd2); // largest period
		repeat (3) begin                                   // three presses: mode flips
			send_word(pwmm_pkg::OP_PRESS, '0, '0);
			send_word(pwmm_pkg::OP_TICK, '0, '0);
		end
		send_word(pwmm_pkg::OP_TICK, '0, '0);              // window shut: mode led off
		send_word(pwmm_pkg::OP_TICK, '0, '0);              // window already at zero

		// random phases: lower extremes, upper extremes, reset values, then
		// random settings; every third phase sends with no gaps at all
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph)
			0: configure('0, '0, '0, '0);
			1: configure(32'hFFFF_FFFF, 16'hFFFF, 7'h7F, 4'hF);
			2: configure(pwmm_pkg::MIN_PERIOD_RST, pwmm_pkg::GPS_LEAD_RST,
			             pwmm_pkg::PRESS_WINDOW_RST, pwmm_pkg::PRESSES_NEEDED_RST);
			default: configure($urandom_range(0, 120),
			                   ($urandom_range(3) == 0) ? 16'($urandom)
			                                            : 16'($urandom_range(0, 80)),
			                   ($urandom_range(3) == 0) ? 7'($urandom_range(0, 127))
			                                            : 7'($urandom_range(1, 12)),
			                   4'($urandom_range(1, 6)));
			endcase
			max_gap = (ph % 3 == 2) ? 0 : $urandom_range(2, 10);
			words_sent = 0;
			while (words_sent < WORDS_PER_PHASE)
				random_item();
		end

		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && flags_owed == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
